// ----- design/nca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared sizes, codes and item types for the nearest-centroid assign chain.
// ----------------------------------------------------------------------------
package nca_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 16;
	localparam int COORD_WIDTH  = 16;

	localparam int CL_W   = $clog2(MAX_CLUSTERS);
	localparam int DIM_W  = $clog2(MAX_DIMS);
	localparam int CNT_W  = 5;
	localparam int MAG_W  = COORD_WIDTH;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int DIST_W = 36;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	typedef struct packed {
		logic                          valid;
		logic                          kind;
		logic [CL_W-1:0]               cl;
		logic [DIM_W-1:0]              dim;
		logic signed [COORD_WIDTH-1:0] val;
		logic                          last;
	} tok_t;

	typedef struct packed {
		logic [CL_W-1:0]   idx;
		logic [DIST_W-1:0] dist_sq;
	} best_t;

endpackage

// ----- design/nca_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_cell
// One cluster cell: holds its centroid row and distance sum, squares the
// coordinate difference, accumulates, and folds its sum into the running
// minimum that walks down the chain.
// ----------------------------------------------------------------------------
module nca_cell import nca_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [CL_W-1:0]  cell_id,
	input  logic [CNT_W-1:0] n_active,
	input  tok_t             tok_in,
	input  best_t            best_in,
	output tok_t             tok_out,
	output best_t            best_out
);

	logic signed [COORD_WIDTH-1:0] row_q [MAX_DIMS];

	tok_t              tok_s1, tok_s2;
	best_t             best_s1, best_s2;
	logic [SQ_W-1:0]   sq_s1;
	logic [DIST_W-1:0] acc_q;

	logic signed [COORD_WIDTH:0] diff;
	logic [COORD_WIDTH:0]        diff_neg;
	logic [MAG_W-1:0]            mag;
	logic [SQ_W-1:0]             sq;
	logic [DIST_W:0]             sum;
	logic [DIST_W-1:0]           acc_new;
	logic                        point_s1;
	logic                        part;
	logic                        take;
	best_t                       best_nx;

	// stage 1: difference and square
	always_comb begin
		diff     = {tok_in.val[COORD_WIDTH-1], tok_in.val}
		         - {row_q[tok_in.dim][COORD_WIDTH-1], row_q[tok_in.dim]};
		diff_neg = -diff;
		mag      = diff[COORD_WIDTH] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
		sq       = mag * mag;
	end

	always_ff @(posedge clk) begin
		if (en && tok_in.valid && tok_in.kind == KIND_LOAD && tok_in.cl == cell_id) begin
			row_q[tok_in.dim] <= tok_in.val;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= sq;
			best_s1 <= best_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (en) begin
			tok_s1 <= tok_in;
		end
	end

	// stage 2: saturating accumulate and compare
	always_comb begin
		point_s1 = tok_s1.valid && tok_s1.kind == KIND_POINT;
		sum      = {1'b0, acc_q} + {{(DIST_W + 1 - SQ_W){1'b0}}, sq_s1};
		acc_new  = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
		part     = {1'b0, cell_id} < n_active;
		take     = (cell_id == '0) || (part && acc_new < best_s1.dist_sq);
		best_nx  = take ? best_t'{idx: cell_id, dist_sq: acc_new} : best_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			tok_s2 <= '0;
		end else if (en) begin
			tok_s2 <= tok_s1;
			if (point_s1) begin
				acc_q <= tok_s1.last ? '0 : acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			best_s2 <= (point_s1 && tok_s1.last) ? best_nx : best_s1;
		end
	end

	assign tok_out  = tok_s2;
	assign best_out = best_s2;

endmodule

// ----- design/nearest_centroid_assign_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top
// K-means nearest-centroid assignment: a chain of one cell per cluster.
//
//   channel   dir  handshake                contents
//   s_axis    in   tvalid/tready            load or point coordinate item
//   m_axis    out  tvalid/tready            nearest cluster and distance
//   cfg       in   cfg_we                   active cluster count
//
// An item enters the chain every cycle while the chain is not halted; each cell
// registers it in stage 1 and stage 2, and m_axis_tvalid is registered from the chain end.
// The chain advances as one; it halts only when a result reaches its end
// while the output register still holds an untaken result.
// Reset clears the sums, the chain and sets the active count to 16.
// Centroid rows are not cleared; load them before sending points.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top import nca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // cluster_index[3:0], dim_index[7:4], coord_value[23:8]
	input  logic        s_axis_tuser,  // kind[0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // best_cluster[3:0], min_sq_distance[39:4]
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	logic [CNT_W-1:0] act_q;
	logic [CNT_W-1:0] n_active;
	tok_t             tok_c  [MAX_CLUSTERS+1];
	best_t            best_c [MAX_CLUSTERS+1];
	logic             res;
	logic             adv;
	logic             m_valid_q;
	best_t            m_best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= CNT_W'(MAX_CLUSTERS);
		end else if (cfg_we) begin
			act_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (act_q == '0) begin
			n_active = CNT_W'(1);
		end else if (act_q > CNT_W'(MAX_CLUSTERS)) begin
			n_active = CNT_W'(MAX_CLUSTERS);
		end else begin
			n_active = act_q;
		end
	end

	assign tok_c[0] = '{
		valid: s_axis_tvalid,
		kind:  s_axis_tuser,
		cl:    s_axis_tdata[3:0],
		dim:   s_axis_tdata[7:4],
		val:   s_axis_tdata[23:8],
		last:  s_axis_tlast
	};
	assign best_c[0] = '0;

	genvar i;
	generate
		for (i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
			nca_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (adv),
				.cell_id  (CL_W'(i)),
				.n_active (n_active),
				.tok_in   (tok_c[i]),
				.best_in  (best_c[i]),
				.tok_out  (tok_c[i+1]),
				.best_out (best_c[i+1])
			);
		end
	endgenerate

	assign res = tok_c[MAX_CLUSTERS].valid && tok_c[MAX_CLUSTERS].kind == KIND_POINT
	          && tok_c[MAX_CLUSTERS].last;
	assign adv = !res || !m_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv && res) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res) begin
			m_best_q <= best_c[MAX_CLUSTERS];
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_best_q.dist_sq, m_best_q.idx};

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (res && m_valid_q && !m_axis_tready))
		else $error("chain halted without a blocked result");

	a_rise_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(res))
		else $error("output valid without a result leaving the chain");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		(n_active >= CNT_W'(1)) && (n_active <= CNT_W'(MAX_CLUSTERS)))
		else $error("active cluster count out of range");

	a_best_active: assert property (@(posedge clk) disable iff (!arst_n)
		res |-> ({1'b0, best_c[MAX_CLUSTERS].idx} < n_active))
		else $error("winner is not an active cluster");

endmodule
